>>> design/key_value_stable_sorter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key/value stable sorter
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_STABLE_SORTER_CORE_ASSERT_SVH
`define KEY_VALUE_STABLE_SORTER_CORE_ASSERT_SVH

// Same-cycle implication
`define KVSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("kvss: same-cycle check failed");

// Next-cycle implication
`define KVSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("kvss: next-cycle check failed");

`endif

>>> design/kvss_pkg.sv
// ----------------------------------------------------------------------------
// kvss_pkg
// Types and state codes shared by the key/value stable sorter files.
// ----------------------------------------------------------------------------
package kvss_pkg;

    // Input transaction: one key/payload pair
    typedef struct packed {
        logic signed [31:0] sort_key;
        logic        [63:0] payload;
        logic               final_item;
    } t_kv_in;

    // Output transaction: one payload in sorted order
    typedef struct packed {
        logic [63:0] sorted_payload;
        logic        end_of_set;
    } t_kv_out;

    // One store entry
    typedef struct packed {
        logic signed [31:0] key;
        logic        [63:0] payload;
    } t_kv_entry;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,   // loading pairs
        ST_SEED,   // read last entry of the set
        ST_PRIME,  // take carried entry, read its left neighbour
        ST_RUN,    // compare and write back, one position a cycle
        ST_TAIL,   // write carried minimum to the head of the pass
        ST_FETCH,  // first read of the emit phase
        ST_LOAD,   // read data into output register
        ST_HOLD    // output waiting for its transaction
    } t_kvss_state;

endpackage

>>> design/kvss_ram.sv
// ----------------------------------------------------------------------------
// kvss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kvss_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/key_value_stable_sorter_core.sv
// ----------------------------------------------------------------------------
// key_value_stable_sorter_core
// Collects key/payload pairs, sorts them by ascending signed key with a
// stable exchange sort held in one RAM, then emits the payloads in order.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                    Payload
//  in       sink       i_in_valid / o_in_stall      t_kv_in  (key, payload, final)
//  out      source     o_out_valid / i_out_stall    t_kv_out (payload, end of set)
//
//  Loading stores each pair as it is taken; pairs beyond MAX_ITEMS are dropped.
//  Sorting n pairs runs n-1 passes over the RAM, each pass reading and writing
//  back one position at a time from the last entry down to the head of the pass.
//  Emitting reads each result into the output register and holds it until taken.
//  Input is stalled from the final pair until the last result is taken.
//  Reset clears the sequencer and fill count; the RAM is not cleared.
// ----------------------------------------------------------------------------
module key_value_stable_sorter_core
    import kvss_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_kv_in  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_kv_out o_out_data
);

    localparam int ADDR_W  = $clog2(MAX_ITEMS);
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W   = CNT_W + 1;
    localparam int ENTRY_W = $bits(t_kv_entry);

    t_kvss_state r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [ADDR_W-1:0] r_pass, n_pass;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_idx, n_idx;
    t_kv_entry         r_carry, n_carry;
    logic              r_out_valid, n_out_valid;
    t_kv_out           r_out, n_out;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    t_kv_entry          ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_kv_entry          rd_entry;

    logic              in_accept;
    logic              store_room;
    logic [CNT_W-1:0]  fill_next;
    logic [CNT_W-1:0]  fill_m1;
    logic [ADDR_W-1:0] last_addr;
    logic              do_swap;
    logic              last_step;
    logic              more_passes;
    logic              at_end;

    // Pair store
    kvss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_kv_entry'(ram_rdata);

    // Handshake and shared terms
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign store_room  = (r_fill < CNT_W'(MAX_ITEMS));
    assign fill_next   = store_room ? (r_fill + CNT_W'(1)) : r_fill;
    assign fill_m1     = r_fill - CNT_W'(1);
    assign last_addr   = fill_m1[ADDR_W-1:0];
    assign do_swap     = (rd_entry.key > r_carry.key);
    assign last_step   = ((r_pos - ADDR_W'(1)) == r_pass);
    assign more_passes = ((CMP_W'(r_pass) + CMP_W'(2)) < CMP_W'(r_fill));
    assign at_end      = (r_idx == last_addr);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && i_in_data.final_item) begin
                    n_state = (fill_next >= CNT_W'(2)) ? ST_SEED : ST_FETCH;
                end
            end
            ST_SEED:  n_state = ST_PRIME;
            ST_PRIME: n_state = ST_RUN;
            ST_RUN:   n_state = last_step ? ST_TAIL : ST_RUN;
            ST_TAIL:  n_state = more_passes ? ST_SEED : ST_FETCH;
            ST_FETCH: n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_HOLD;
            ST_HOLD: begin
                if (!i_out_stall) begin
                    n_state = at_end ? ST_IDLE : ST_LOAD;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_fill      = r_fill;
        n_pass      = r_pass;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_carry     = r_carry;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_carry;
        ram_re      = 1'b0;
        ram_raddr   = r_pos;
        unique case (r_state)
            ST_IDLE: begin
                n_pass = '0;
                n_idx  = '0;
                if (in_accept && store_room) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_fill[ADDR_W-1:0];
                    ram_wdata = '{key: i_in_data.sort_key, payload: i_in_data.payload};
                end
                if (in_accept) begin
                    n_fill = fill_next;
                end
            end
            ST_SEED: begin
                ram_re    = 1'b1;
                ram_raddr = last_addr;
                n_pos     = last_addr;
            end
            ST_PRIME: begin
                n_carry   = rd_entry;
                ram_re    = 1'b1;
                ram_raddr = r_pos - ADDR_W'(1);
            end
            ST_RUN: begin
                // Smaller key moves on left; equal keys keep their order
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = do_swap ? rd_entry : r_carry;
                n_carry   = do_swap ? r_carry : rd_entry;
                n_pos     = r_pos - ADDR_W'(1);
                if (!last_step) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_pos - ADDR_W'(2);
                end
            end
            ST_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = r_pass;
                ram_wdata = r_carry;
                n_pass    = r_pass + ADDR_W'(1);
            end
            ST_FETCH: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
            end
            ST_LOAD: begin
                n_out.sorted_payload = rd_entry.payload;
                n_out.end_of_set     = at_end;
                n_out_valid          = 1'b1;
            end
            ST_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (at_end) begin
                        n_fill = '0;
                    end else begin
                        n_idx     = r_idx + ADDR_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_pass      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pass      <= n_pass;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_carry <= n_carry;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> design/kvss_checker.sv
// ----------------------------------------------------------------------------
// kvss_checker
// Port-level checks for the key/value stable sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_value_stable_sorter_core_assert.svh"

module kvss_checker
    import kvss_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_stall,
    input t_kv_in  i_in_data,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_kv_out o_out_data
);

    // A stalled result holds
    `KVSS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // No input is taken while a result is on offer
    `KVSS_ASSERT_NOW(a_no_overlap, o_out_valid, o_in_stall)

    // A final pair closes the input side
    `KVSS_ASSERT_NEXT(a_final_stalls, i_in_valid && !o_in_stall && i_in_data.final_item, o_in_stall)

    // After the last result the block is ready for a new set
    `KVSS_ASSERT_NEXT(a_end_reopens, o_out_valid && !i_out_stall && o_out_data.end_of_set, !o_in_stall && !o_out_valid)

endmodule

bind key_value_stable_sorter_core kvss_checker u_kvss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
